### rtl/udiv_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the unsigned restoring divider
// no dependencies

package udiv_pkg;

    // default operand width
    localparam int DATA_WIDTH_DEF = 64;

    // control from the sequencer to the row of divider cells
    typedef struct packed {
        logic load;  // capture new operands, clear partial remainder
        logic step;  // perform one restoring shift-subtract step
    } t_chain_ctrl;

    // sequencer states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

endpackage

### rtl/udiv_cell.sv
`timescale 1ns / 1ps
// one bit slice of the restoring divider: remainder, quotient and divisor bit
// depends on udiv_pkg

module udiv_cell
    import udiv_pkg::*;
(
    input  logic        i_clk,
    input  t_chain_ctrl i_ctrl,
    input  logic        i_ld_quo,    // dividend bit at load
    input  logic        i_ld_dvs,    // divisor bit at load
    input  logic        i_t,         // shifted partial remainder bit from the lower neighbor
    input  logic        i_borrow,    // borrow from the lower neighbor
    input  logic        i_ge,        // subtraction succeeded across the whole row
    input  logic        i_q_in,      // quotient bit shifted in from the lower neighbor
    output logic        o_rem,
    output logic        o_quo,
    output logic        o_borrow,
    output logic        o_next_rem,
    output logic        o_next_quo
);

    logic r_rem;
    logic r_quo;
    logic r_dvs;
    logic n_diff;

    // one bit of the trial subtraction
    assign n_diff   = i_t ^ r_dvs ^ i_borrow;
    assign o_borrow = (~i_t & r_dvs) | (~(i_t ^ r_dvs) & i_borrow);

    // keep the difference or restore the shifted remainder
    assign o_next_rem = i_ge ? n_diff : i_t;
    assign o_next_quo = i_q_in;

    assign o_rem = r_rem;
    assign o_quo = r_quo;

    // slice state
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_rem <= 1'b0;
            r_quo <= i_ld_quo;
            r_dvs <= i_ld_dvs;
        end else if (i_ctrl.step) begin
            r_rem <= o_next_rem;
            r_quo <= o_next_quo;
        end
    end

endmodule

### rtl/udiv_chain.sv
`timescale 1ns / 1ps
// row of divider cells with the borrow ripple and the restore decision
// depends on udiv_pkg and udiv_cell

module udiv_chain
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  t_chain_ctrl           i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic [DATA_WIDTH-1:0] o_next_rem,
    output logic [DATA_WIDTH-1:0] o_next_quo
);

    logic [DATA_WIDTH-1:0] rem_bits;
    logic [DATA_WIDTH-1:0] quo_bits;
    logic [DATA_WIDTH-1:0] borrow_bits;
    logic [DATA_WIDTH-1:0] t_bits;
    logic [DATA_WIDTH-1:0] borrow_in;
    logic [DATA_WIDTH-1:0] q_in;
    logic                  ge;

    // shifted partial remainder: remainder up one, next dividend bit at the bottom
    assign t_bits    = {rem_bits[DATA_WIDTH-2:0], quo_bits[DATA_WIDTH-1]};
    assign borrow_in = {borrow_bits[DATA_WIDTH-2:0], 1'b0};
    assign q_in      = {quo_bits[DATA_WIDTH-2:0], ge};

    // trial value fits when the bit shifted out is set or no borrow leaves the row
    assign ge = rem_bits[DATA_WIDTH-1] | ~borrow_bits[DATA_WIDTH-1];

    // the cells
    for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
        udiv_cell u_cell (
            .i_clk      (i_clk),
            .i_ctrl     (i_ctrl),
            .i_ld_quo   (i_dividend[i]),
            .i_ld_dvs   (i_divisor[i]),
            .i_t        (t_bits[i]),
            .i_borrow   (borrow_in[i]),
            .i_ge       (ge),
            .i_q_in     (q_in[i]),
            .o_rem      (rem_bits[i]),
            .o_quo      (quo_bits[i]),
            .o_borrow   (borrow_bits[i]),
            .o_next_rem (o_next_rem[i]),
            .o_next_quo (o_next_quo[i])
        );
    end

endmodule

### rtl/unsigned_divider_64.sv
`timescale 1ns / 1ps
// unsigned restoring divider top level: sequencer, result register, checks
// depends on udiv_pkg and udiv_chain

// A transaction is taken when start is high and busy is low. A nonzero divisor
// runs through a row of DATA_WIDTH bit cells that produce one quotient bit per
// clock, one restoring step per quotient bit, and the result then passes through
// the result register before the result strobe o_valid; busy is low again in
// the strobe cycle. A zero divisor gives its result (quotient 0, remainder equal
// to the dividend, o_divide_by_zero high) in the cycle after the transaction
// and leaves busy low. Results show for exactly one cycle and cannot be held
// off, so capture them on o_valid.

module unsigned_divider_64
    import udiv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [DATA_WIDTH-1:0] i_dividend,
    input  logic [DATA_WIDTH-1:0] i_divisor,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_quotient,
    output logic [DATA_WIDTH-1:0] o_remainder,
    output logic                  o_divide_by_zero
);

    localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

    t_state                r_state;
    t_state                n_state;
    logic [CNT_W-1:0]      r_count;
    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_quotient;
    logic [DATA_WIDTH-1:0] r_remainder;
    logic                  r_dbz;
    logic                  accept;
    logic                  dvs_zero;
    logic                  last_step;
    t_chain_ctrl           ctrl;
    logic [DATA_WIDTH-1:0] next_rem;
    logic [DATA_WIDTH-1:0] next_quo;

    assign busy     = (r_state == S_RUN);
    assign accept   = start && !busy;
    assign dvs_zero = (i_divisor == '0);
    assign last_step = busy && (r_count == '0);

    // cell row control
    assign ctrl.load = accept && !dvs_zero;
    assign ctrl.step = busy;

    udiv_chain #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctrl     (ctrl),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_next_rem (next_rem),
        .o_next_quo (next_quo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && !dvs_zero) n_state = S_RUN;
            end
            S_RUN: begin
                if (last_step) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (accept && dvs_zero) || last_step;
            if (ctrl.load) begin
                r_count <= CNT_W'(DATA_WIDTH - 1);
            end else if (busy) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (accept && dvs_zero) begin
            r_quotient  <= '0;
            r_remainder <= i_dividend;
            r_dbz       <= 1'b1;
        end else if (last_step) begin
            r_quotient  <= next_quo;
            r_remainder <= next_rem;
            r_dbz       <= 1'b0;
        end
    end

    assign o_valid          = r_valid;
    assign o_quotient       = r_quotient;
    assign o_remainder      = r_remainder;
    assign o_divide_by_zero = r_dbz;

`ifndef SYNTHESIS
    // no result leaves while the cell row is still working
    assert property (@(posedge i_clk) disable iff (!i_rst_n) busy |-> !o_valid)
        else $error("result strobe while divider busy");

    // a nonzero divisor starts the cell row
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_divisor != '0)) |=> busy)
        else $error("division did not start");

    // divide by zero reports a zero quotient
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_quotient == '0))
        else $error("nonzero quotient on divide by zero");

    // the last step hands a result out on the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && (r_count == '0)) |=> (o_valid && !o_divide_by_zero))
        else $error("missing result after last step");
`endif

endmodule
